// ===== hdl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

  localparam int unsigned ModW   = 31;
  localparam int unsigned OpW    = 63;
  localparam int unsigned CntW   = 6;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [ModW-1:0] MODULUS_RESET = 31'd1000000007;
  localparam logic [ModW-1:0] ONE           = 31'd1;

  // Register index taken from the word address
  localparam logic REG_MODULUS = 1'b0;

  // Last step index for a full-width base reduction and for a residue operand
  localparam logic [CntW-1:0] LAST_BASE    = 6'd62;
  localparam logic [CntW-1:0] LAST_RESIDUE = 6'd30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } mexp_state_t;

  // One job for the shared modular multiplier: (a * b) mod m, with b
  // left-aligned and consumed MSB first for last+1 steps.
  typedef struct packed {
    logic            go;
    logic [ModW-1:0] a;
    logic [OpW-1:0]  b;
    logic [CntW-1:0] last;
  } mexp_mul_req_t;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// Top level: modular exponentiation sequencer, multiplier and register port.
`timescale 1ns / 1ps
// Computes base_value ** exponent mod modulus by right-to-left square and
// multiply. A transaction is accepted when start is high and busy is low;
// busy then stays high until the result has been shown. The result appears on
// out_power_result for exactly one cycle with out_valid high and cannot be
// held off, so capture it in that cycle. The work is done by a single
// bit-serial modular multiplier that consumes one operand bit per cycle: it
// first reduces the base, then runs k multiplies and squares, where k =
// popcount(exponent) + bitlength(exponent) - 1 (k = 0 for a zero exponent);
// busy drops in the cycle after the strobe. The worst case is an exponent
// with all 63 bits set. A modulus below two gives a zero result in the
// cycle after accept. The modulus lives at APB byte address 0 and must
// only be written while idle. For a modular inverse with a prime modulus,
// set exponent to modulus - 2.
module modular_exponentiation import mexp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // Command channel
  input  logic             start,
  output logic             busy,
  input  logic [OpW-1:0]   in_base_value,
  input  logic [OpW-1:0]   in_exponent,
  // Result strobe
  output logic             out_valid,
  output logic [ModW-1:0]  out_power_result,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  mexp_state_t     state_r, state_nxt;
  logic [ModW-1:0] acc_r, acc_nxt;
  logic [ModW-1:0] sq_r, sq_nxt;
  logic [OpW-1:0]  expo_r, expo_nxt;

  logic [ModW-1:0] modulus;
  mexp_mul_req_t   req;
  logic            mul_done;
  logic [ModW-1:0] mul_result;
  logic            dispatch;
  logic [OpW-1:0]  e;

  mexp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .modulus (modulus)
  );

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .modulus (modulus),
    .done    (mul_done),
    .result  (mul_result)
  );

  // Sequencer: reduce the base, then walk the exponent LSB first. A set bit
  // folds the current square into the accumulator; the square is advanced
  // only while higher exponent bits remain.
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    expo_nxt  = expo_r;
    req       = '0;
    dispatch  = 1'b0;
    e         = expo_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (modulus < 31'd2) begin
            // Degenerate modulus: everything reduces to zero
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            // Reduce the base: (1 * base) mod m over all 63 bits
            expo_nxt  = in_exponent;
            req.go    = 1'b1;
            req.a     = ONE;
            req.b     = in_base_value;
            req.last  = LAST_BASE;
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_done) begin
          sq_nxt   = mul_result;
          acc_nxt  = ONE;
          dispatch = 1'b1;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          acc_nxt = mul_result;
          if (expo_r[OpW-1:1] == '0) begin
            state_nxt = ST_FIN;
          end else begin
            req.go    = 1'b1;
            req.a     = sq_r;
            req.b     = {sq_r, {(OpW-ModW){1'b0}}};
            req.last  = LAST_RESIDUE;
            state_nxt = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          sq_nxt   = mul_result;
          e        = {1'b0, expo_r[OpW-1:1]};
          expo_nxt = e;
          dispatch = 1'b1;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Pick the next job from the remaining exponent bits
    if (dispatch) begin
      if (e == '0) begin
        state_nxt = ST_FIN;
      end else if (e[0]) begin
        req.go    = 1'b1;
        req.a     = acc_nxt;
        req.b     = {sq_nxt, {(OpW-ModW){1'b0}}};
        req.last  = LAST_RESIDUE;
        state_nxt = ST_MUL;
      end else begin
        req.go    = 1'b1;
        req.a     = sq_nxt;
        req.b     = {sq_nxt, {(OpW-ModW){1'b0}}};
        req.last  = LAST_RESIDUE;
        state_nxt = ST_SQR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath holds; no reset needed
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    sq_r   <= sq_nxt;
    expo_r <= expo_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_FIN);
  assign out_power_result = acc_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_power_result < modulus) ||
                   ((modulus < 31'd2) && (out_power_result == '0))))
    else $error("result out of range");

endmodule

// ===== hdl/mexp_regs.sv =====
// APB configuration register: the modulus.
`timescale 1ns / 1ps
module mexp_regs import mexp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [ModW-1:0]  modulus
);

  logic [ModW-1:0] modulus_r;
  logic [ModW-1:0] modulus_nxt;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    modulus_nxt = modulus_r;
    if (wr_en && (paddr[2] == REG_MODULUS)) begin
      modulus_nxt = pwdata[ModW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODULUS: prdata = {{(DataW-ModW){1'b0}}, modulus_r};
      default:     prdata = '0;
    endcase
  end

  assign modulus = modulus_r;

endmodule

// ===== hdl/mexp_mulmod.sv =====
// Shared bit-serial modular multiplier: one operand bit per cycle.
`timescale 1ns / 1ps
module mexp_mulmod import mexp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  mexp_mul_req_t   req,
  input  logic [ModW-1:0] modulus,
  output logic            done,
  output logic [ModW-1:0] result
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [ModW-1:0] a_r, a_nxt;
  logic [OpW-1:0]  b_r, b_nxt;
  logic [ModW-1:0] r_r, r_nxt;

  logic [ModW:0] m_ext;
  logic [ModW:0] dbl;
  logic [ModW:0] dbl_red;
  logic [ModW:0] sum;
  logic [ModW:0] sum_red;

  // Double, reduce, add the selected multiple, reduce again
  always_comb begin
    m_ext   = {1'b0, modulus};
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[ModW-1:0]} + {1'b0, (b_r[OpW-1] ? a_r : {ModW{1'b0}})};
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.last;
      a_nxt    = req.a;
      b_nxt    = req.b;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt = sum_red[ModW-1:0];
      b_nxt = {b_r[OpW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    r_r   <= r_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !busy_r)
    else $error("mulmod job issued while busy");

  a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (r_r < modulus))
    else $error("mulmod result not reduced");

endmodule

// ===== tb/tb_modular_exponentiation.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps
module tb_modular_exponentiation;
  import mexp_pkg::*;

  // Byte addresses on the register port: modulus at word 0, nothing at word 1
  localparam logic [AddrW-1:0] ADDR_MODULUS = AddrW'({REG_MODULUS, 2'b00});
  localparam logic [AddrW-1:0] ADDR_UNUSED  = AddrW'(4);

  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned ITEMS_PER_PHASE = 96;
  // Must exceed the longest transaction, from accept to result strobe
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES    = 100;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef enum logic [1:0] {
    ITEM_POWER,
    ITEM_REG_WRITE,
    ITEM_REG_READ
  } item_kind_t;

  typedef struct {
    item_kind_t      kind;
    logic [OpW-1:0]  base_value;
    logic [OpW-1:0]  exponent;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } pending_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             start = 1'b0;
  logic             busy;
  logic [OpW-1:0]   in_base_value = '0;
  logic [OpW-1:0]   in_exponent = '0;
  logic             out_valid;
  logic [ModW-1:0]  out_power_result;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  pending_item_t   pending_q[$];
  logic [ModW-1:0] expected_power_q[$];

  // Modulus as the block should hold it, and as the stimulus generator
  // expects it to be once the queued writes have gone through
  logic [ModW-1:0] modulus_shadow = MODULUS_RESET;
  logic [ModW-1:0] gen_modulus = MODULUS_RESET;

  int unsigned error_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  int unsigned idle_cycles = 0;

  modular_exponentiation uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base_value    (in_base_value),
    .in_exponent      (in_exponent),
    .out_valid        (out_valid),
    .out_power_result (out_power_result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Right-to-left square and multiply; every product stays below 2^62
  function automatic logic [ModW-1:0] power_mod(logic [OpW-1:0] base_in,
                                                logic [OpW-1:0] expo_in,
                                                logic [ModW-1:0] modulus);
    logic [63:0]    m;
    logic [63:0]    sq;
    logic [63:0]    acc;
    logic [OpW-1:0] expo;
    if (modulus < 2) begin
      return '0;
    end
    m    = 64'(modulus);
    sq   = 64'(base_in) % m;
    acc  = 64'd1;
    expo = expo_in;
    while (expo != '0) begin
      if (expo[0]) begin
        acc = (acc * sq) % m;
      end
      sq   = (sq * sq) % m;
      expo = expo >> 1;
    end
    return acc[ModW-1:0];
  endfunction

  // Idle gap before the next transaction; now and then a run with no gaps
  function automatic int unsigned draw_gap();
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic note_mismatch(string what, logic [ModW-1:0] want, logic [ModW-1:0] got);
    error_cnt++;
    if (error_cnt <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic add_power(logic [OpW-1:0] base_value, logic [OpW-1:0] exponent);
    pending_item_t item;
    item = '{ITEM_POWER, base_value, exponent, ADDR_MODULUS, '0};
    pending_q.push_back(item);
  endtask

  task automatic add_reg_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    pending_item_t item;
    item = '{ITEM_REG_WRITE, '0, '0, addr, data};
    pending_q.push_back(item);
    if (addr == ADDR_MODULUS) begin
      gen_modulus = data[ModW-1:0];
    end
  endtask

  task automatic add_reg_read();
    pending_item_t item;
    item = '{ITEM_REG_READ, '0, '0, ADDR_MODULUS, '0};
    pending_q.push_back(item);
  endtask

  function automatic logic [OpW-1:0] rand_wide();
    return OpW'({$urandom, $urandom});
  endfunction

  function automatic logic [OpW-1:0] rand_base();
    logic [OpW-1:0] k;
    case ($urandom_range(0, 7))
      0: return OpW'($urandom_range(0, 20));
      1: begin
        // Land on or right beside a multiple of the modulus
        k = OpW'($urandom_range(0, 1000));
        return k * OpW'(gen_modulus) + OpW'($urandom_range(0, 2)) - OpW'(1);
      end
      2: return '1;
      default: return rand_wide();
    endcase
  endfunction

  // Mostly short exponents keep the run short; a few full-width ones and
  // inverse-style ones (modulus minus two) reach the long paths
  function automatic logic [OpW-1:0] rand_exponent();
    int unsigned sel;
    int unsigned width;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      return rand_wide();
    end
    if (sel < 12 && gen_modulus >= 2) begin
      return OpW'(gen_modulus) - OpW'(2);
    end
    width = $urandom_range(0, 16);
    return rand_wide() & ((OpW'(1) << width) - OpW'(1));
  endfunction

  function automatic logic [DataW-1:0] rand_modulus_word();
    case ($urandom_range(0, 9))
      0: return DataW'(2147483647);
      1: return DataW'(1000000007);
      2: return DataW'($urandom_range(2, 1000));
      3: return DataW'($urandom_range(0, 1));
      default: return $urandom;
    endcase
  endfunction

  // Driver: present queued transactions on the command channel or the
  // register port. Register accesses wait until the block is fully idle.
  always @(posedge clk) begin : driver
    logic          next_start;
    pending_item_t item;
    next_start = start;
    if (!rst_n) begin
      next_start     = 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      modulus_shadow = MODULUS_RESET;
      gap_left       = 0;
    end else begin
      if (start && !busy) begin
        // Transaction accepted at this edge: predict it with the live modulus
        expected_power_q.push_back(power_mod(in_base_value, in_exponent, modulus_shadow));
        next_start = 1'b0;
        gap_left   = draw_gap();
      end else if (psel && penable) begin
        // Access phase completes now since pready is tied high
        if (pwrite) begin
          if (paddr == ADDR_MODULUS) begin
            modulus_shadow = pwdata[ModW-1:0];
          end
        end else if (prdata[ModW-1:0] !== modulus_shadow) begin
          note_mismatch("modulus readback", modulus_shadow, prdata[ModW-1:0]);
        end
        psel     <= 1'b0;
        penable  <= 1'b0;
        gap_left = draw_gap();
      end else if (psel) begin
        penable <= 1'b1;
      end else if (!start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          item = pending_q[0];
          if (item.kind == ITEM_POWER) begin
            void'(pending_q.pop_front());
            in_base_value <= item.base_value;
            in_exponent   <= item.exponent;
            next_start    = 1'b1;
          end else if (!busy && !out_valid) begin
            // Hold register traffic until the last result has gone out
            void'(pending_q.pop_front());
            psel   <= 1'b1;
            pwrite <= (item.kind == ITEM_REG_WRITE);
            paddr  <= item.addr;
            pwdata <= item.data;
          end
        end
      end
    end
    start <= next_start;
  end

  // Monitor: a result exists for exactly one cycle; compare it with the
  // oldest prediction
  always @(posedge clk) begin : monitor
    logic [ModW-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_power_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= REPORT_LIMIT) begin
          $display("%0t: result %0d with no transaction outstanding", $realtime,
                   out_power_result);
        end
      end else begin
        want = expected_power_q.pop_front();
        if (out_power_result !== want) begin
          note_mismatch("power_result", want, out_power_result);
        end
      end
    end
  end

  // Watchdog: drop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("modular_exponentiation test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Directed part, reset modulus first: zero cases, full-width operands,
    // bases at the modulus, and an inverse
    add_reg_read();
    add_power('0, '0);
    add_power('0, OpW'(5));
    add_power(OpW'(5), '0);
    add_power('1, '1);
    add_power(OpW'(MODULUS_RESET), OpW'(3));
    add_power(OpW'(MODULUS_RESET) - OpW'(1), OpW'(2));
    add_power(OpW'(2), OpW'(MODULUS_RESET) - OpW'(2));
    // Largest modulus
    add_reg_write(ADDR_MODULUS, DataW'(2147483647));
    add_power('1, '1);
    add_power(OpW'(2147483646), OpW'(3));
    // Smallest proper modulus
    add_reg_write(ADDR_MODULUS, DataW'(2));
    add_power(OpW'(3), '1);
    add_power(OpW'(2), OpW'(1));
    // Degenerate moduli reduce everything to zero
    add_reg_write(ADDR_MODULUS, DataW'(0));
    add_power(OpW'(7), OpW'(3));
    add_power('0, '0);
    add_reg_write(ADDR_MODULUS, DataW'(1));
    add_power(OpW'(7), '0);
    // Write to an unmapped word is dropped
    add_reg_write(ADDR_MODULUS, DataW'(3));
    add_reg_write(ADDR_UNUSED, DataW'(5));
    add_reg_read();
    add_power(OpW'(2), OpW'(3));
    // Bit 31 of the write data falls outside the register
    add_reg_write(ADDR_MODULUS, 32'h8000_000B);
    add_reg_read();
    add_power(OpW'(2), OpW'(10));
    add_power(OpW'(3), OpW'(9));

    // Random phases, each under a fresh modulus
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        add_reg_write(ADDR_MODULUS, DataW'(2147483647));
      end else if (phase == 1) begin
        add_reg_write(ADDR_MODULUS, DataW'(2));
      end else begin
        add_reg_write(ADDR_MODULUS, rand_modulus_word());
      end
      if ($urandom_range(0, 3) == 0) begin
        add_reg_write(ADDR_UNUSED, $urandom);
      end
      add_reg_read();
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        add_power(rand_base(), rand_exponent());
      end
    end
    // End on the reset value
    add_reg_write(ADDR_MODULUS, DataW'(MODULUS_RESET));
    add_reg_read();
    add_power(rand_wide(), rand_exponent());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Advance until all stimulus is out and every result has come back
    while (pending_q.size() != 0 || start || psel || busy || expected_power_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_cnt == 0 && expected_power_q.size() == 0) begin
      $display("modular_exponentiation test passed");
    end else begin
      $display("modular_exponentiation test failed");
    end
    $finish;
  end

endmodule

// ===== modular_exponentiation.f =====
hdl/mexp_pkg.sv
hdl/mexp_regs.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation.sv
tb/tb_modular_exponentiation.sv
